### hw/rtl/front_coded_string_encoder_unit_macros.svh
// Assertion macros for the front coded string encoder.
`ifndef FRONT_CODED_STRING_ENCODER_UNIT_MACROS_SVH
`define FRONT_CODED_STRING_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fec assertion failed");
`define FEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fec assertion failed");
`else
`define FEC_ASSERT_NOW(lbl, ante, cons)
`define FEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/fec_pkg.sv
package fec_pkg;

  localparam int unsigned ByteW              = 8;
  localparam int unsigned LenW               = 13;
  localparam int unsigned MaxStringBytesDef  = 4096;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic             empty_string;
    logic             first_of_page;
  } in_item_t;

  typedef struct packed {
    logic             suffix_valid;
    logic [ByteW-1:0] suffix_out;
    logic             lengths_valid;
    logic [LenW-1:0]  prefix_length;
    logic [LenW-1:0]  suffix_length;
    logic             too_long;
  } out_item_t;

endpackage

### hw/rtl/fec_ram.sv
module fec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/front_coded_string_encoder_unit.sv
// Accepted items are registered in the compare stage, their results in the output
// register. Throughput: one item per cycle unless the output stalls; the
// previous-string memory is read on accept and written as an item leaves the compare stage.
// Reset: asynchronous, active low; clears counters, lengths and valids at once.
// Memory contents are not cleared and need no clearing pass.
`include "front_coded_string_encoder_unit_macros.svh"

module front_coded_string_encoder_unit
  import fec_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = MaxStringBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(MAX_STRING_BYTES);
  localparam int unsigned PW = $clog2(MAX_STRING_BYTES + 1);
  localparam logic [PW-1:0] MaxPos = PW'(MAX_STRING_BYTES);

  logic          accept;
  logic          out_free;
  logic          s1_fire;
  logic [PW-1:0] pos0_q, pos0_d;

  logic          s1_valid_q, s1_valid_d;
  in_item_t      s1_item_q;
  logic [PW-1:0] s1_pos_q;
  logic          fwd_q;
  logic [ByteW-1:0] fwd_byte_q;

  logic [PW-1:0] prev_len_q, prev_len_d;
  logic [PW-1:0] prefix_q, prefix_d;
  logic          match_q, match_d;
  logic          ovf_q, ovf_d;

  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  logic [PW-1:0] plen_eff;
  logic          in_store;
  logic          is_byte;
  logic [ByteW-1:0] old_byte;
  logic          byte_match;
  logic [PW-1:0] pos_after;
  logic [PW-1:0] prefix_next;
  logic          match_next;
  logic          ovf_next;
  logic          str_end;
  logic          sfx_valid;
  logic          has_result;
  out_item_t     result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // read address tracking, ahead of the compare stage
  always_comb begin
    pos0_d = pos0_q;
    if (accept) begin
      if (in_item_i.empty_string || in_item_i.last_byte) begin
        pos0_d = '0;
      end else if (pos0_q < MaxPos) begin
        pos0_d = pos0_q + PW'(1);
      end
    end
  end

  assign ram_re    = accept && (pos0_q < MaxPos);
  assign ram_raddr = pos0_q[AW-1:0];

  // compare stage
  assign plen_eff   = (s1_pos_q == '0 && s1_item_q.first_of_page) ? '0 : prev_len_q;
  assign in_store   = s1_pos_q < MaxPos;
  assign is_byte    = !s1_item_q.empty_string;
  assign old_byte   = fwd_q ? fwd_byte_q : ram_rdata;
  assign byte_match = match_q && (s1_pos_q < plen_eff) && (old_byte == s1_item_q.data_byte);
  assign pos_after  = (is_byte && in_store) ? s1_pos_q + PW'(1) : s1_pos_q;
  assign prefix_next = (is_byte && in_store && byte_match) ? prefix_q + PW'(1) : prefix_q;
  assign match_next = is_byte ? (in_store && byte_match) : match_q;
  assign ovf_next   = ovf_q || (is_byte && !in_store);
  assign str_end    = s1_item_q.empty_string || s1_item_q.last_byte;
  assign sfx_valid  = is_byte && !(in_store && byte_match);
  assign has_result = sfx_valid || str_end;

  assign ram_we    = s1_fire && is_byte && in_store;
  assign ram_waddr = s1_pos_q[AW-1:0];

  always_comb begin
    result.suffix_valid  = sfx_valid;
    result.suffix_out    = sfx_valid ? s1_item_q.data_byte : '0;
    result.lengths_valid = str_end;
    result.prefix_length = str_end ? LenW'(prefix_next) : '0;
    result.suffix_length = str_end ? LenW'(pos_after - prefix_next) : '0;
    result.too_long      = str_end && ovf_next;
  end

  always_comb begin
    prev_len_d = prev_len_q;
    prefix_d   = prefix_q;
    match_d    = match_q;
    ovf_d      = ovf_q;
    if (s1_fire) begin
      if (str_end) begin
        prev_len_d = pos_after;
        prefix_d   = '0;
        match_d    = 1'b1;
        ovf_d      = 1'b0;
      end else begin
        prev_len_d = plen_eff;
        prefix_d   = prefix_next;
        match_d    = match_next;
        ovf_d      = ovf_next;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_fire && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos0_q      <= '0;
      s1_valid_q  <= 1'b0;
      prev_len_q  <= '0;
      prefix_q    <= '0;
      match_q     <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos0_q      <= pos0_d;
      s1_valid_q  <= s1_valid_d;
      prev_len_q  <= prev_len_d;
      prefix_q    <= prefix_d;
      match_q     <= match_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // forward a write that lands on the address being read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_item_i;
      s1_pos_q   <= pos0_q;
      fwd_q      <= ram_we && (ram_waddr == ram_raddr);
      fwd_byte_q <= s1_item_q.data_byte;
    end
    if (s1_fire && has_result) begin
      out_item_q <= result;
    end
  end

  fec_ram #(
    .Width(ByteW),
    .Depth(MAX_STRING_BYTES)
  ) u_prev_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s1_item_q.data_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `FEC_ASSERT_NOW(a_pos0_range, 1'b1, pos0_q <= MaxPos)
  `FEC_ASSERT_NOW(a_out_nonempty, out_valid_q, out_item_q.suffix_valid || out_item_q.lengths_valid)
  `FEC_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_fire, s1_valid_q && $stable(s1_pos_q))

endmodule

### tb/sv/tb_front_coded_string_encoder_unit.sv
module tb_front_coded_string_encoder_unit;
  import fec_pkg::*;

  localparam int unsigned StoreBytes = MaxStringBytesDef;
  localparam int unsigned RandomItems = 650;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  front_coded_string_encoder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  in_item_t    pending_items[$];
  out_item_t   expected_codes[$];
  logic [7:0]  sent_text[$];
  int unsigned errors = 0;
  int unsigned cycle_no = 0;
  bit          in_taken = 1'b0;
  out_item_t   want_code;

  logic [7:0]  last_text[StoreBytes];
  int unsigned last_len = 0;
  int unsigned text_pos = 0;
  int unsigned shared_len = 0;
  bit          still_same = 1'b1;
  bit          past_store = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #3000000;
    $display("tb_front_coded_string_encoder_unit failed");
    $finish;
  end

  function automatic bit calm_window();
    return cycle_no >= 3000 && cycle_no < 7000;
  endfunction

  function automatic logic [7:0] pick_byte();
    return ($urandom_range(99) < 30) ? 8'($urandom_range(255)) : 8'($urandom_range(97, 100));
  endfunction

  function automatic void queue_string(input logic [7:0] text[$], input bit new_page,
                                       input bit end_by_empty);
    in_item_t item;
    for (int i = 0; i < text.size(); i++) begin
      item.data_byte     = text[i];
      item.last_byte     = (i == text.size() - 1) && !end_by_empty;
      item.empty_string  = 1'b0;
      item.first_of_page = (i == 0) ? new_page : 1'($urandom_range(1));
      pending_items.push_back(item);
    end
    if (end_by_empty || text.size() == 0) begin
      item.data_byte     = 8'($urandom_range(255));
      item.last_byte     = 1'($urandom_range(1));
      item.empty_string  = 1'b1;
      item.first_of_page = (text.size() == 0) ? new_page : 1'($urandom_range(1));
      pending_items.push_back(item);
    end
    if (text.size() > StoreBytes) begin
      sent_text = text[0:StoreBytes-1];
    end else begin
      sent_text = text;
    end
  endfunction

  task automatic encode_item(input in_item_t item);
    out_item_t res;
    res = '0;
    if (text_pos == 0 && item.first_of_page) begin
      last_len = 0;
    end
    if (!item.empty_string) begin
      if (text_pos < StoreBytes) begin
        if (still_same && text_pos < last_len && last_text[text_pos] == item.data_byte) begin
          shared_len++;
        end else begin
          still_same       = 1'b0;
          res.suffix_valid = 1'b1;
          res.suffix_out   = item.data_byte;
        end
        last_text[text_pos] = item.data_byte;
        text_pos++;
      end else begin
        past_store       = 1'b1;
        still_same       = 1'b0;
        res.suffix_valid = 1'b1;
        res.suffix_out   = item.data_byte;
      end
    end
    if (item.empty_string || item.last_byte) begin
      res.lengths_valid = 1'b1;
      res.prefix_length = LenW'(shared_len);
      res.suffix_length = LenW'(text_pos - shared_len);
      res.too_long      = past_store;
      last_len   = text_pos;
      text_pos   = 0;
      shared_len = 0;
      still_same = 1'b1;
      past_store = 1'b0;
    end
    if (res.suffix_valid || res.lengths_valid) begin
      expected_codes.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [LenW-1:0] got,
                                 input logic [LenW-1:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_no, field, got, want);
    errors++;
  endtask

  // drive input items and output stalls on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && (calm_window() || $urandom_range(99) >= 21)) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm_window() && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      cycle_no++;
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        encode_item(in_item);
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (expected_codes.size() == 0) begin
          report_mismatch("unexpected item", '0, '0);
        end else begin
          want_code = expected_codes.pop_front();
          if (out_item.suffix_valid !== want_code.suffix_valid)
            report_mismatch("suffix_valid", LenW'(out_item.suffix_valid),
                            LenW'(want_code.suffix_valid));
          if (out_item.suffix_out !== want_code.suffix_out)
            report_mismatch("suffix_out", LenW'(out_item.suffix_out),
                            LenW'(want_code.suffix_out));
          if (out_item.lengths_valid !== want_code.lengths_valid)
            report_mismatch("lengths_valid", LenW'(out_item.lengths_valid),
                            LenW'(want_code.lengths_valid));
          if (out_item.prefix_length !== want_code.prefix_length)
            report_mismatch("prefix_length", out_item.prefix_length, want_code.prefix_length);
          if (out_item.suffix_length !== want_code.suffix_length)
            report_mismatch("suffix_length", out_item.suffix_length, want_code.suffix_length);
          if (out_item.too_long !== want_code.too_long)
            report_mismatch("too_long", LenW'(out_item.too_long),
                            LenW'(want_code.too_long));
        end
      end
    end
  end

  initial begin
    logic [7:0]  word[$];
    logic [7:0]  huge[$];
    int unsigned keep;
    int unsigned extra;
    int unsigned long_items;
    int unsigned directed_items;
    bit          long_done;

    long_items = 0;
    long_done  = 1'b0;

    word = '{8'h00, 8'hFF};
    queue_string(word, 1'b1, 1'b0);
    queue_string(word, 1'b0, 1'b0);
    word = '{8'h00, 8'h7F};
    queue_string(word, 1'b0, 1'b0);
    pending_items[$].first_of_page = 1'b1;
    word = {};
    queue_string(word, 1'b0, 1'b0);
    word = '{8'h61, 8'h62};
    queue_string(word, 1'b0, 1'b1);
    word = '{8'h61, 8'h62, 8'h63};
    queue_string(word, 1'b0, 1'b0);
    queue_string(word, 1'b1, 1'b0);
    word = '{8'h61, 8'h62, 8'h78};
    queue_string(word, 1'b0, 1'b0);
    word = {};
    queue_string(word, 1'b1, 1'b0);
    pending_items[$].last_byte = 1'b1;
    pending_items[$].data_byte = 8'hFF;
    word = '{8'hAA, 8'h55};
    queue_string(word, 1'b0, 1'b1);
    directed_items = pending_items.size();

    while (pending_items.size() - long_items - directed_items < RandomItems) begin
      if (!long_done && pending_items.size() - directed_items > 300) begin
        long_done = 1'b1;
        keep = pending_items.size();
        huge = {};
        repeat (StoreBytes + 3) huge.push_back(pick_byte());
        queue_string(huge, 1'b1, 1'b0);
        word = huge[0:StoreBytes-1];
        word.push_back(pick_byte());
        word.push_back(pick_byte());
        queue_string(word, 1'b0, 1'b0);
        word = huge[0:StoreBytes-1];
        queue_string(word, 1'b0, 1'b1);
        word[4000] = ~word[4000];
        queue_string(word, 1'b0, 1'b0);
        long_items = pending_items.size() - keep;
      end
      word = {};
      if ($urandom_range(99) < 10) begin
        extra = $urandom_range(8);
        repeat (extra) word.push_back(8'($urandom_range(255)));
      end else begin
        keep = $urandom_range(sent_text.size());
        for (int i = 0; i < keep; i++) word.push_back(sent_text[i]);
        extra = $urandom_range(6);
        repeat (extra) word.push_back(pick_byte());
      end
      queue_string(word, $urandom_range(99) < 8, $urandom_range(99) < 10);
    end

    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_front_coded_string_encoder_unit passed");
    end else begin
      $display("tb_front_coded_string_encoder_unit failed");
    end
    $finish;
  end

endmodule
